FILE: hw/rtl/uti_pkg.sv
// Shared constants and types for the uniform table interpolator.
// No dependencies; every other file refers to this package by scoped names.
package uti_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int IDX_LSB       = 2 * FRAC_BITS;
  localparam int BLEND_W       = DATA_W + FRAC_BITS + 2;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W     = 2;

  // configuration register indices
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ORIGIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_PER_UNIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_INDEX      = 2'd2;

  localparam logic [DATA_W-1:0] GRID_ORIGIN_RST     = 32'd0;
  localparam logic [DATA_W-1:0] POINTS_PER_UNIT_RST = 32'd65536;
  localparam logic [ADDR_W-1:0] LAST_INDEX_RST      = 8'd200;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_WRITE = 2'd0;
  localparam kind_t KIND_BELOW = 2'd1;
  localparam kind_t KIND_ABOVE = 2'd2;
  localparam kind_t KIND_MID   = 2'd3;

  // classified operation handed from front to back
  typedef struct packed {
    kind_t                 kind;
    logic [ADDR_W-1:0]     addr;
    logic [FRAC_BITS-1:0]  frac;
    logic [DATA_W-1:0]     wdata;
  } q_entry_t;

endpackage

FILE: hw/rtl/uti_if.sv
// Channel interfaces: item input, result output and configuration write.
// Depends on uti_pkg for widths.
interface uti_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [uti_pkg::ADDR_W-1:0]       entry_index;
  logic signed [uti_pkg::DATA_W-1:0] entry_value;
  logic signed [uti_pkg::DATA_W-1:0] query_value;

  modport source (output valid, action, entry_index, entry_value, query_value, input ready);
  modport sink   (input valid, action, entry_index, entry_value, query_value, output ready);
endinterface

interface uti_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [uti_pkg::DATA_W-1:0] result_value;
  logic                             below_range;
  logic                             above_range;

  modport source (output valid, result_value, below_range, above_range, input ready);
  modport sink   (input valid, result_value, below_range, above_range, output ready);
endinterface

interface uti_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [uti_pkg::CFG_IDX_W-1:0]     index;
  logic [uti_pkg::DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/uniform_table_interpolator.sv
// Uniform-grid interpolation table. A query passes the front stages, the queue and the
// back stages; a table write lands in the RAM as it leaves the queue. Throughput: one
// item per cycle while out_ch is ready, set by the fully pipelined front and back with
// a 4-entry queue between them. Reset (rst_n, synchronous) clears pipeline control and
// loads config defaults; table contents are undefined until written, no clearing pass.
module uniform_table_interpolator (
  input  logic      clk,
  input  logic      rst_n,
  uti_in_if.sink    in_ch,
  uti_out_if.source out_ch,
  uti_cfg_if.sink   cfg_ch
);

  uti_pkg::q_entry_t push_entry, pop_entry;
  logic              push_valid, push_ready;
  logic              pop_valid, pop_ready;

  uti_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  uti_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  uti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

FILE: hw/rtl/uti_front.sv
// Front end: config registers, item acceptance, position arithmetic and classification.
// Depends on uti_pkg and the channel interfaces in uti_if.
module uti_front (
  input  logic               clk,
  input  logic               rst_n,
  uti_in_if.sink             in_ch,
  uti_cfg_if.sink            cfg_ch,
  output uti_pkg::q_entry_t  push_entry,
  output logic               push_valid,
  input  logic               push_ready
);

  logic [uti_pkg::DATA_W-1:0] grid_origin_r;
  logic [uti_pkg::DATA_W-1:0] points_per_unit_r;
  logic [uti_pkg::ADDR_W-1:0] last_index_r;

  logic pipe_en;

  // stage 1: difference
  logic                          s1_valid_r, s1_act_r;
  logic [uti_pkg::ADDR_W-1:0]    s1_idx_r;
  logic [uti_pkg::DATA_W-1:0]    s1_wval_r;
  logic signed [uti_pkg::DATA_W:0] s1_diff_r, s1_diff_nxt;

  // stage 2: magnitude
  logic                          s2_valid_r, s2_act_r, s2_neg_r;
  logic [uti_pkg::ADDR_W-1:0]    s2_idx_r;
  logic [uti_pkg::DATA_W-1:0]    s2_wval_r;
  logic [uti_pkg::DATA_W-1:0]    s2_mag_r, s2_mag_nxt;
  logic signed [uti_pkg::DATA_W:0] diff_neg;

  // stage 3: product
  logic                          s3_valid_r, s3_act_r, s3_neg_r;
  logic [uti_pkg::ADDR_W-1:0]    s3_idx_r;
  logic [uti_pkg::DATA_W-1:0]    s3_wval_r;
  logic [uti_pkg::PROD_W-1:0]    s3_prod_r, s3_prod_nxt;

  logic is_below, is_above;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_origin_r     <= uti_pkg::GRID_ORIGIN_RST;
      points_per_unit_r <= uti_pkg::POINTS_PER_UNIT_RST;
      last_index_r      <= uti_pkg::LAST_INDEX_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        uti_pkg::CFG_GRID_ORIGIN:     grid_origin_r     <= cfg_ch.data;
        uti_pkg::CFG_POINTS_PER_UNIT: points_per_unit_r <= cfg_ch.data;
        uti_pkg::CFG_LAST_INDEX:      last_index_r      <= cfg_ch.data[uti_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // whole front moves together; stalls only when the tail cannot enter the queue
  assign pipe_en     = !s3_valid_r || push_ready;
  assign in_ch.ready = pipe_en;

  assign s1_diff_nxt = {in_ch.query_value[uti_pkg::DATA_W-1], in_ch.query_value}
                     - {grid_origin_r[uti_pkg::DATA_W-1], grid_origin_r};
  assign diff_neg    = -s1_diff_r;
  // |diff| < 2^32, so the magnitude fits the lower bits
  assign s2_mag_nxt  = s1_diff_r[uti_pkg::DATA_W] ? diff_neg[uti_pkg::DATA_W-1:0]
                                                  : s1_diff_r[uti_pkg::DATA_W-1:0];
  assign s3_prod_nxt = uti_pkg::PROD_W'(s2_mag_r) * uti_pkg::PROD_W'(points_per_unit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (pipe_en) begin
      s1_valid_r <= in_ch.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_act_r  <= in_ch.action;
      s1_idx_r  <= in_ch.entry_index;
      s1_wval_r <= in_ch.entry_value;
      s1_diff_r <= s1_diff_nxt;
      s2_act_r  <= s1_act_r;
      s2_idx_r  <= s1_idx_r;
      s2_wval_r <= s1_wval_r;
      s2_neg_r  <= s1_diff_r[uti_pkg::DATA_W];
      s2_mag_r  <= s2_mag_nxt;
      s3_act_r  <= s2_act_r;
      s3_idx_r  <= s2_idx_r;
      s3_wval_r <= s2_wval_r;
      s3_neg_r  <= s2_neg_r;
      s3_prod_r <= s3_prod_nxt;
    end
  end

  // a zero product with negative difference is not below range; it is position 0
  assign is_below = s3_neg_r && (s3_prod_r != '0);
  assign is_above = (s3_prod_r[uti_pkg::PROD_W-1:uti_pkg::IDX_LSB+uti_pkg::ADDR_W] != '0)
                 || (s3_prod_r[uti_pkg::IDX_LSB+uti_pkg::ADDR_W-1:uti_pkg::IDX_LSB]
                     >= last_index_r);

  always_comb begin
    push_entry       = '0;
    push_entry.wdata = s3_wval_r;
    if (!s3_act_r) begin
      push_entry.kind = uti_pkg::KIND_WRITE;
      push_entry.addr = s3_idx_r;
    end else if (is_below) begin
      push_entry.kind = uti_pkg::KIND_BELOW;
      push_entry.addr = '0;
    end else if (is_above) begin
      push_entry.kind = uti_pkg::KIND_ABOVE;
      push_entry.addr = last_index_r;
    end else begin
      push_entry.kind = uti_pkg::KIND_MID;
      push_entry.addr = s3_prod_r[uti_pkg::IDX_LSB+uti_pkg::ADDR_W-1:uti_pkg::IDX_LSB];
      push_entry.frac = s3_prod_r[uti_pkg::IDX_LSB-1:uti_pkg::FRAC_BITS];
    end
  end

  assign push_valid = s3_valid_r;

  // an interior point always has a right-hand neighbour inside the table
  a_mid_below_last: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && push_entry.kind == uti_pkg::KIND_MID |-> push_entry.addr < last_index_r)
    else $error("interior index not below last index");

endmodule

FILE: hw/rtl/uti_queue.sv
// Short FIFO of classified operations between front and back.
// Depends on uti_pkg for the entry type and depth.
module uti_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  uti_pkg::q_entry_t  push_entry,
  input  logic               push_valid,
  output logic               push_ready,
  output uti_pkg::q_entry_t  pop_entry,
  output logic               pop_valid,
  input  logic               pop_ready
);

  uti_pkg::q_entry_t             entries_r [uti_pkg::QUEUE_DEPTH];
  logic [uti_pkg::QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [uti_pkg::QUEUE_AW:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (cnt_r != (uti_pkg::QUEUE_AW+1)'(uti_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (uti_pkg::QUEUE_AW+1)'(uti_pkg::QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == (uti_pkg::QUEUE_AW+1)'(uti_pkg::QUEUE_DEPTH))
      |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with occupancy");

endmodule

FILE: hw/rtl/uti_back.sv
// Back end: table RAM, neighbour reads, linear blend and result register.
// Depends on uti_pkg and the output interface in uti_if.
module uti_back (
  input  logic               clk,
  input  logic               rst_n,
  input  uti_pkg::q_entry_t  pop_entry,
  input  logic               pop_valid,
  output logic               pop_ready,
  uti_out_if.source          out_ch
);

  logic [uti_pkg::DATA_W-1:0] mem [uti_pkg::TABLE_ENTRIES];

  logic                        en, take;
  logic [uti_pkg::ADDR_W-1:0]  addr1;

  logic                          b1_valid_r;
  uti_pkg::kind_t                b1_kind_r;
  logic [uti_pkg::FRAC_BITS-1:0] b1_frac_r;
  logic [uti_pkg::DATA_W-1:0]    rd0_r, rd1_r;

  logic                            b2_valid_r;
  uti_pkg::kind_t                  b2_kind_r;
  logic [uti_pkg::FRAC_BITS-1:0]   b2_frac_r;
  logic [uti_pkg::DATA_W-1:0]      b2_t0_r;
  logic signed [uti_pkg::DATA_W:0] b2_delta_r, b2_delta_nxt;

  logic                                b3_valid_r;
  uti_pkg::kind_t                      b3_kind_r;
  logic [uti_pkg::DATA_W-1:0]          b3_t0_r;
  logic signed [uti_pkg::BLEND_W-1:0]  b3_prod_r, b3_prod_nxt;

  logic                        out_valid_r;
  logic [uti_pkg::DATA_W-1:0]  out_value_r, out_value_nxt;
  logic                        out_below_r, out_above_r;

  assign en        = !out_valid_r || out_ch.ready;
  assign pop_ready = en;
  assign take      = pop_valid && en;
  assign addr1     = pop_entry.addr + uti_pkg::ADDR_W'(1);

  // writes and reads meet the RAM at the same stage, so order is kept
  always_ff @(posedge clk) begin
    if (take && pop_entry.kind == uti_pkg::KIND_WRITE) begin
      mem[pop_entry.addr] <= pop_entry.wdata;
    end
    if (en) begin
      rd0_r <= mem[pop_entry.addr];
      rd1_r <= mem[addr1];
    end
  end

  assign b2_delta_nxt  = {rd1_r[uti_pkg::DATA_W-1], rd1_r} - {rd0_r[uti_pkg::DATA_W-1], rd0_r};
  assign b3_prod_nxt   = uti_pkg::BLEND_W'(b2_delta_r)
                       * uti_pkg::BLEND_W'($signed({1'b0, b2_frac_r}));
  // floor(prod / 2^FRAC_BITS) is an arithmetic shift; only its low word matters
  assign out_value_nxt = (b3_kind_r == uti_pkg::KIND_MID)
    ? b3_t0_r + b3_prod_r[uti_pkg::FRAC_BITS+uti_pkg::DATA_W-1:uti_pkg::FRAC_BITS]
    : b3_t0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      b1_valid_r  <= take && (pop_entry.kind != uti_pkg::KIND_WRITE);
      b2_valid_r  <= b1_valid_r;
      b3_valid_r  <= b2_valid_r;
      out_valid_r <= b3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_kind_r   <= pop_entry.kind;
      b1_frac_r   <= pop_entry.frac;
      b2_kind_r   <= b1_kind_r;
      b2_frac_r   <= b1_frac_r;
      b2_t0_r     <= rd0_r;
      b2_delta_r  <= b2_delta_nxt;
      b3_kind_r   <= b2_kind_r;
      b3_t0_r     <= b2_t0_r;
      b3_prod_r   <= b3_prod_nxt;
      out_value_r <= out_value_nxt;
      out_below_r <= (b3_kind_r == uti_pkg::KIND_BELOW);
      out_above_r <= (b3_kind_r == uti_pkg::KIND_ABOVE);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_value_r;
  assign out_ch.below_range  = out_below_r;
  assign out_ch.above_range  = out_above_r;

  a_no_write_in_blend: assert property (@(posedge clk) disable iff (!rst_n)
    b1_valid_r |-> b1_kind_r != uti_pkg::KIND_WRITE)
    else $error("table write carried into the blend pipeline");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_below_r && out_above_r))
    else $error("both range flags set");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for uniform_table_interpolator: table loads, lookups and
// register settings, with random idling on both channels and a lookup checker class.
// Depends on uti_pkg and the channel interfaces in uti_if.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_WRITE      = 1'b0;
  localparam logic ACT_QUERY      = 1'b1;
  localparam int   LATENCY_CYCLES = 10;
  localparam int   HOLD_CYCLES    = 100;

  typedef struct {
    logic signed [uti_pkg::DATA_W-1:0] value;
    logic                              below;
    logic                              above;
  } lookup_result_t;

  // Mirror of the table and grid registers; predicts each lookup and checks it
  class lookup_checker;
    logic signed [uti_pkg::DATA_W-1:0] entries [uti_pkg::TABLE_ENTRIES];
    logic signed [uti_pkg::DATA_W-1:0] origin;
    logic        [uti_pkg::DATA_W-1:0] scale;
    logic        [uti_pkg::ADDR_W-1:0] last_idx;
    lookup_result_t                    pending_lookups [$];
    int                                errors;

    function new();
      origin   = uti_pkg::GRID_ORIGIN_RST;
      scale    = uti_pkg::POINTS_PER_UNIT_RST;
      last_idx = uti_pkg::LAST_INDEX_RST;
      errors   = 0;
    endfunction

    function void set_register(logic [uti_pkg::CFG_IDX_W-1:0] index,
                               logic [uti_pkg::DATA_W-1:0] data);
      case (index)
        uti_pkg::CFG_GRID_ORIGIN:     origin   = data;
        uti_pkg::CFG_POINTS_PER_UNIT: scale    = data;
        uti_pkg::CFG_LAST_INDEX:      last_idx = data[uti_pkg::ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function lookup_result_t interpolate(logic signed [uti_pkg::DATA_W-1:0] query);
      lookup_result_t              r;
      longint                      diff, lo, hi, blend;
      bit [63:0]                   mag, product, pos_q, seg_idx;
      bit [uti_pkg::FRAC_BITS-1:0] frac;
      diff    = longint'(query) - longint'(origin);
      mag     = (diff < 0) ? -diff : diff;
      product = mag * {32'd0, scale};
      r.below = 1'b0;
      r.above = 1'b0;
      if (diff < 0 && product != 0) begin
        // anything left of the first point, however small, clamps low
        r.value = entries[0];
        r.below = 1'b1;
      end else begin
        pos_q   = product >> uti_pkg::FRAC_BITS;
        seg_idx = pos_q >> uti_pkg::FRAC_BITS;
        frac    = pos_q[uti_pkg::FRAC_BITS-1:0];
        if (seg_idx >= last_idx) begin
          r.value = entries[last_idx];
          r.above = 1'b1;
        end else begin
          lo      = entries[seg_idx];
          hi      = entries[seg_idx + 1];
          blend   = ((hi - lo) * longint'(frac)) >>> uti_pkg::FRAC_BITS;  // floor
          r.value = lo + blend;
        end
      end
      return r;
    endfunction

    function void record_item(logic action, logic [uti_pkg::ADDR_W-1:0] slot,
                              logic [uti_pkg::DATA_W-1:0] value,
                              logic [uti_pkg::DATA_W-1:0] query);
      if (action == ACT_WRITE)
        entries[slot] = value;
      else
        pending_lookups.push_back(interpolate(query));
    endfunction

    function void check_result(logic [uti_pkg::DATA_W-1:0] value, logic below, logic above);
      lookup_result_t e;
      if (pending_lookups.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got value %h below %b above %b",
                 $time, value, below, above);
        errors++;
        return;
      end
      e = pending_lookups.pop_front();
      if (value !== e.value) begin
        $display("%0t ns: result_value expected %h, got %h", $time, e.value, value);
        errors++;
      end
      if (below !== e.below) begin
        $display("%0t ns: below_range expected %b, got %b", $time, e.below, below);
        errors++;
      end
      if (above !== e.above) begin
        $display("%0t ns: above_range expected %b, got %b", $time, e.above, above);
        errors++;
      end
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_request = 1'b0;
  bit   no_idling    = 1'b0;

  lookup_checker sb = new();

  uti_in_if  in_ch ();
  uti_out_if out_ch ();
  uti_cfg_if cfg_ch ();

  uniform_table_interpolator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.record_item(in_ch.action, in_ch.entry_index, in_ch.entry_value, in_ch.query_value);
    if (rst_n && cfg_ch.valid && cfg_ch.ready)
      sb.set_register(cfg_ch.index, cfg_ch.data);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_value, out_ch.below_range, out_ch.above_range);
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [uti_pkg::DATA_W-1:0] fresh_entry();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return $urandom_range(0, 2000) - 1000;
  endfunction

  // Most lookups aim at positions from one point below the grid to two past its end
  function automatic logic [uti_pkg::DATA_W-1:0] aim_query();
    longint pos_q, target;
    if (sb.scale == 0 || $urandom_range(0, 3) == 0) return $urandom();
    pos_q  = longint'($urandom_range(0, (int'(sb.last_idx) + 3) << uti_pkg::FRAC_BITS))
             - (longint'(1) << uti_pkg::FRAC_BITS);
    target = longint'(sb.origin) + (pos_q <<< uti_pkg::FRAC_BITS) / longint'(sb.scale);
    if (target > 64'sd2147483647)
      target = 64'sd2147483647;
    else if (target < -64'sd2147483648)
      target = -64'sd2147483648;
    return target[uti_pkg::DATA_W-1:0];
  endfunction

  // receiver: random stalls, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (no_idling || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (idle_cycles() - 1) @(negedge clk);
      end
    end
  end

  task automatic offer_item(input logic act, input logic [uti_pkg::ADDR_W-1:0] slot,
                            input logic [uti_pkg::DATA_W-1:0] value,
                            input logic [uti_pkg::DATA_W-1:0] query);
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.entry_index <= slot;
    in_ch.entry_value <= value;
    in_ch.query_value <= query;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_entry(input logic [uti_pkg::ADDR_W-1:0] slot,
                             input logic [uti_pkg::DATA_W-1:0] value);
    offer_item(ACT_WRITE, slot, value, $urandom());
  endtask

  task automatic lookup(input logic [uti_pkg::DATA_W-1:0] query);
    offer_item(ACT_QUERY, uti_pkg::ADDR_W'($urandom()), $urandom(), query);
  endtask

  task automatic sender_gap();
    int n;
    n = (no_idling || $urandom_range(0, 99) < 55) ? 0 : idle_cycles();
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic random_item();
    if ($urandom_range(0, 4) == 0)
      write_entry(uti_pkg::ADDR_W'($urandom()), fresh_entry());
    else
      lookup(aim_query());
    sender_gap();
  endtask

  task automatic run_items(input int count);
    repeat (count) random_item();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [uti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uti_pkg::DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // registers change only once the pipeline has emptied, writes included
  task automatic set_grid(input logic [uti_pkg::DATA_W-1:0] origin,
                          input logic [uti_pkg::DATA_W-1:0] scale,
                          input logic [uti_pkg::ADDR_W-1:0] last);
    wait_drained();
    repeat (LATENCY_CYCLES) @(posedge clk);
    write_reg(uti_pkg::CFG_GRID_ORIGIN, origin);
    write_reg(uti_pkg::CFG_POINTS_PER_UNIT, scale);
    write_reg(uti_pkg::CFG_LAST_INDEX,
              {{(uti_pkg::DATA_W-uti_pkg::ADDR_W){1'b0}}, last});
  endtask

  initial begin
    logic [uti_pkg::DATA_W-1:0] scale;
    int                         pick;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_WRITE;
    in_ch.entry_index  = '0;
    in_ch.entry_value  = '0;
    in_ch.query_value  = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = uti_pkg::CFG_GRID_ORIGIN;
    cfg_ch.data        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // load every slot before any lookup can touch it
    for (int s = 0; s < uti_pkg::TABLE_ENTRIES; s++) begin
      write_entry(s[uti_pkg::ADDR_W-1:0], fresh_entry());
      sender_gap();
    end

    // directed: reset grid, origin 0, one point per unit, last index 200
    write_entry(8'd0, 32'h7fff_ffff);
    write_entry(8'd1, 32'h8000_0000);
    lookup(32'h0000_8000);               // straight after the writes, steep fall
    lookup(32'h0000_0000);               // exactly on the first point
    lookup(32'h0001_0000);
    lookup(32'hffff_ffff);               // tiny negative position clamps low
    lookup(32'h8000_0000);
    lookup(32'h7fff_ffff);
    lookup(32'h00c8_0000);               // on the last index
    lookup(32'h00c7_ffff);               // top fraction of the last segment
    write_entry(8'd255, 32'h8000_0000);
    write_entry(8'd200, 32'h7fff_ffff);
    lookup(32'h00ff_0000);
    write_entry(8'd2, 32'h8000_0000);
    write_entry(8'd3, 32'h7fff_ffff);
    lookup(32'h0002_ffff);               // steep rise, fraction all ones
    lookup(32'h0002_0001);

    run_items(20);
    // long output hold while lookups keep coming, then let everything drain
    hold_request = 1'b1;
    repeat (24) lookup(aim_query());
    wait_drained();
    run_items(20);

    // extremes: lowest origin with the largest scale, so overflowing products clamp high
    set_grid(32'h8000_0000, 32'hffff_ffff, 8'd255);
    run_items(30);
    // zero scale: every position is zero
    set_grid(32'h7fff_ffff, 32'h0000_0000, 8'd1);
    run_items(25);
    // zero last index: every non-negative position clamps high
    set_grid($urandom(), 32'h0001_0000, 8'd0);
    run_items(25);

    for (int p = 0; p < 7; p++) begin
      pick = $urandom_range(0, 3);
      if (pick == 0)
        scale = $urandom();
      else if (pick == 1)
        scale = $urandom_range(1, 255);
      else
        scale = $urandom_range(1 << 13, 1 << 19);
      set_grid(($urandom_range(0, 3) == 0) ? $urandom()
                 : $urandom_range(0, 200 << uti_pkg::FRAC_BITS)
                   - (100 << uti_pkg::FRAC_BITS),
               scale, uti_pkg::ADDR_W'($urandom_range(1, 255)));
      no_idling = (p == 3);
      run_items(50);
    end
    no_idling = 1'b0;

    wait_drained();
    repeat (2 * LATENCY_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS uniform_table_interpolator");
    else
      $display("FAIL uniform_table_interpolator");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL uniform_table_interpolator");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/uti_pkg.sv
hw/rtl/uti_if.sv
hw/rtl/uti_front.sv
hw/rtl/uti_queue.sv
hw/rtl/uti_back.sv
hw/rtl/uniform_table_interpolator.sv
tb/sv/testbench.sv
